[rtl/pva_pkg.sv]
// Shared types and constants for the polyphonic voice allocator.
`default_nettype none

package pva_pkg;

  // Default sizes handed to the top-level parameters, and the fixed field widths.
  localparam int VOICES_DEF   = 8;
  localparam int AGE_BITS_DEF = 32;
  localparam int KEY_W        = 7;
  localparam int VEL_W        = 7;
  localparam int MASK_W       = 8;

  // Event codes on the input word.
  typedef enum logic [1:0] {
    MODE_ON      = 2'd0,
    MODE_OFF     = 2'd1,
    MODE_ALL_OFF = 2'd2,
    MODE_DONE    = 2'd3
  } mode_t;

  // Action codes on the result word.
  typedef enum logic [1:0] {
    ACT_START   = 2'd0,
    ACT_RELEASE = 2'd1,
    ACT_KILL    = 2'd2,
    ACT_FREED   = 2'd3
  } action_t;

  // How a started slot was picked.
  typedef enum logic [1:0] {
    HOW_RETRIG = 2'd0,
    HOW_IDLE   = 2'd1,
    HOW_STEAL  = 2'd2
  } how_t;

  // Sequencer states of the top level.
  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_SWEEP  = 2'd1,
    S_FINISH = 2'd2
  } state_t;

  // Input word.
  typedef struct packed {
    logic [1:0]       mode;
    logic [KEY_W-1:0] key;
    logic [VEL_W-1:0] velocity;
    logic [2:0]       done_slot;
  } in_word_t;

  // Result word.
  typedef struct packed {
    logic [1:0]        action;
    logic [2:0]        slot;
    logic [1:0]        how_chosen;
    logic [KEY_W-1:0]  start_key;
    logic [VEL_W-1:0]  start_velocity;
    logic [MASK_W-1:0] release_mask;
  } out_word_t;

  // Search record that travels down the cell chain.
  typedef struct packed {
    logic              valid;
    logic              found_match;
    logic              found_idle;
    logic              has_best;
    logic [KEY_W-1:0]  key;
    logic [MASK_W-1:0] mask;
  } rec_t;

  // Update command broadcast to every cell.
  typedef struct packed {
    logic             write;
    logic             kill_all;
    logic             free;
    logic [KEY_W-1:0] key;
  } cmd_t;

endpackage

`default_nettype wire

[rtl/pva_cell.sv]
// One voice slot: holds its state and refines the search record passing by.
`default_nettype none

module pva_cell #(
  parameter int IDX      = 0,
  parameter int SLOT_W   = 3,
  parameter int AGE_BITS = 32
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  pva_pkg::rec_t       rec_in,
  input  wire  [SLOT_W-1:0]   match_in,
  input  wire  [SLOT_W-1:0]   idle_in,
  input  wire  [SLOT_W-1:0]   best_in,
  input  wire  [AGE_BITS-1:0] age_in,
  output pva_pkg::rec_t       rec_out,
  output logic [SLOT_W-1:0]   match_out,
  output logic [SLOT_W-1:0]   idle_out,
  output logic [SLOT_W-1:0]   best_out,
  output logic [AGE_BITS-1:0] age_out,
  input  pva_pkg::cmd_t       cmd,
  input  wire  [SLOT_W-1:0]   cmd_slot,
  input  wire  [AGE_BITS-1:0] cmd_age
);
  import pva_pkg::*;

  localparam logic [SLOT_W-1:0] MY_IDX = SLOT_W'(IDX);
  localparam logic [MASK_W-1:0] MY_BIT = (IDX < MASK_W) ? MASK_W'(1 << IDX) : '0;

  logic                active_r;
  logic [KEY_W-1:0]    key_r;
  logic [AGE_BITS-1:0] slot_age_r;

  rec_t                rec_r, rec_nxt;
  logic [SLOT_W-1:0]   match_r, match_nxt;
  logic [SLOT_W-1:0]   idle_r, idle_nxt;
  logic [SLOT_W-1:0]   best_r, best_nxt;
  logic [AGE_BITS-1:0] age_r, age_nxt;
  logic                hit;
  logic                mine;

  assign hit  = active_r && (key_r == rec_in.key);
  assign mine = (cmd_slot == MY_IDX);

  // Fold this slot into the search record.
  always_comb begin
    rec_nxt   = rec_in;
    match_nxt = match_in;
    idle_nxt  = idle_in;
    best_nxt  = best_in;
    age_nxt   = age_in;
    if (!rec_in.found_match && hit) begin
      rec_nxt.found_match = 1'b1;
      match_nxt           = MY_IDX;
    end
    if (!rec_in.found_idle && !active_r) begin
      rec_nxt.found_idle = 1'b1;
      idle_nxt           = MY_IDX;
    end
    // Strict compare keeps the lower index on equal ages.
    if (!rec_in.has_best || (slot_age_r < age_in)) begin
      rec_nxt.has_best = 1'b1;
      best_nxt         = MY_IDX;
      age_nxt          = slot_age_r;
    end
    rec_nxt.mask = rec_in.mask | (hit ? MY_BIT : '0);
  end

  // Record stage toward the next cell.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_r <= '0;
    end else begin
      rec_r <= rec_nxt;
    end
    match_r <= match_nxt;
    idle_r  <= idle_nxt;
    best_r  <= best_nxt;
    age_r   <= age_nxt;
  end

  assign rec_out   = rec_r;
  assign match_out = match_r;
  assign idle_out  = idle_r;
  assign best_out  = best_r;
  assign age_out   = age_r;

  // Slot state, changed only by the broadcast command.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else if (cmd.kill_all || (cmd.free && mine)) begin
      active_r <= 1'b0;
    end else if (cmd.write && mine) begin
      active_r <= 1'b1;
    end
    if (cmd.write && mine) begin
      key_r      <= cmd.key;
      slot_age_r <= cmd_age;
    end
  end

endmodule

`default_nettype wire

[rtl/poly_voice_allocator.sv]
// Top level of the polyphonic voice allocator: sequencer, age counter and cell chain.
//
//   Channel | Direction | Handshake          | Word
//   in_     | input     | in_valid/in_stall   | pva_pkg::in_word_t
//   out_    | output    | out_valid/out_stall | pva_pkg::out_word_t
//
// Each event sends one search record down the chain of slot cells, each cell
// registering it in turn; the sequencer then latches the finished search, and
// the commit step updates the slot and loads the output register.
// Reset is synchronous and active low; it clears every active bit and the age counter.
// A stall on a full output register holds the finished event in the commit step;
// the next event is taken once that commit has returned the sequencer to idle.
`default_nettype none

module poly_voice_allocator #(
  parameter int VOICES   = pva_pkg::VOICES_DEF,
  parameter int AGE_BITS = pva_pkg::AGE_BITS_DEF
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  input  pva_pkg::in_word_t   in_data,
  output logic                out_valid,
  input  wire                 out_stall,
  output pva_pkg::out_word_t  out_data
);
  import pva_pkg::*;

  localparam int SLOT_W = $clog2(VOICES);
  localparam logic [5:0] VOICES_L = 6'(VOICES);

  state_t              state_r, state_nxt;
  in_word_t            req_r;
  rec_t                fnd_r;
  logic [SLOT_W-1:0]   fnd_match_r, fnd_idle_r, fnd_best_r;
  logic [AGE_BITS-1:0] age_ctr_r;
  logic                out_valid_r;
  out_word_t           out_data_r;

  logic                accept;
  logic                fire;
  logic                is_on;
  logic [SLOT_W-1:0]   chosen;
  how_t                how;
  logic [SLOT_W+2:0]   chosen_ext;
  logic [SLOT_W+2:0]   done_ext;
  logic                done_ok;
  out_word_t           res;
  cmd_t                cmd;
  logic [SLOT_W-1:0]   cmd_slot;
  logic [AGE_BITS-1:0] age_next;

  rec_t                chain_rec   [VOICES+1];
  logic [SLOT_W-1:0]   chain_match [VOICES+1];
  logic [SLOT_W-1:0]   chain_idle  [VOICES+1];
  logic [SLOT_W-1:0]   chain_best  [VOICES+1];
  logic [AGE_BITS-1:0] chain_age   [VOICES+1];

  assign accept   = in_valid && (state_r == S_IDLE);
  assign in_stall = (state_r != S_IDLE);
  assign fire     = (state_r == S_FINISH) && (!out_valid_r || !out_stall);

  // Seed record entering the first cell.
  always_comb begin
    chain_rec[0]       = '0;
    chain_rec[0].valid = accept;
    chain_rec[0].key   = in_data.key;
    chain_match[0]     = '0;
    chain_idle[0]      = '0;
    chain_best[0]      = '0;
    chain_age[0]       = '0;
  end

  // Chain of slot cells.
  for (genvar g = 0; g < VOICES; g++) begin : g_cell
    pva_cell #(
      .IDX      (g),
      .SLOT_W   (SLOT_W),
      .AGE_BITS (AGE_BITS)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .rec_in    (chain_rec[g]),
      .match_in  (chain_match[g]),
      .idle_in   (chain_idle[g]),
      .best_in   (chain_best[g]),
      .age_in    (chain_age[g]),
      .rec_out   (chain_rec[g+1]),
      .match_out (chain_match[g+1]),
      .idle_out  (chain_idle[g+1]),
      .best_out  (chain_best[g+1]),
      .age_out   (chain_age[g+1]),
      .cmd       (cmd),
      .cmd_slot  (cmd_slot),
      .cmd_age   (age_next)
    );
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_SWEEP;
      end
      S_SWEEP: begin
        if (chain_rec[VOICES].valid) state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (fire) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Capture the event and the finished search.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_data;
    end
    if ((state_r == S_SWEEP) && chain_rec[VOICES].valid) begin
      fnd_r       <= chain_rec[VOICES];
      fnd_match_r <= chain_match[VOICES];
      fnd_idle_r  <= chain_idle[VOICES];
      fnd_best_r  <= chain_best[VOICES];
    end
  end

  // Slot choice: retrigger first, then lowest idle slot, then oldest.
  always_comb begin
    if (fnd_r.found_match) begin
      chosen = fnd_match_r;
      how    = HOW_RETRIG;
    end else if (fnd_r.found_idle) begin
      chosen = fnd_idle_r;
      how    = HOW_IDLE;
    end else begin
      chosen = fnd_best_r;
      how    = HOW_STEAL;
    end
  end

  assign is_on      = (req_r.mode == MODE_ON) && (req_r.velocity != '0);
  assign age_next   = age_ctr_r + AGE_BITS'(1);
  assign chosen_ext = {3'b000, chosen};
  assign done_ext   = {SLOT_W'(0), req_r.done_slot};
  assign done_ok    = ({3'b000, req_r.done_slot} < VOICES_L);

  // Result word and slot update command.
  always_comb begin
    res      = '0;
    cmd      = '0;
    cmd_slot = chosen;
    cmd.key  = req_r.key;
    if (is_on) begin
      res.action         = ACT_START;
      res.slot           = chosen_ext[2:0];
      res.how_chosen     = how;
      res.start_key      = req_r.key;
      res.start_velocity = req_r.velocity;
      cmd.write          = fire;
    end else if ((req_r.mode == MODE_ON) || (req_r.mode == MODE_OFF)) begin
      res.action       = ACT_RELEASE;
      res.release_mask = fnd_r.mask;
    end else if (req_r.mode == MODE_ALL_OFF) begin
      res.action   = ACT_KILL;
      cmd.kill_all = fire;
    end else begin
      res.action = ACT_FREED;
      res.slot   = req_r.done_slot;
      cmd.free   = fire && done_ok;
      cmd_slot   = done_ext[SLOT_W-1:0];
    end
  end

  // Age counter advances on every started voice.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      age_ctr_r <= '0;
    end else if (fire && is_on) begin
      age_ctr_r <= age_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (fire) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

[verif/tb_poly_voice_allocator.sv]
// Self-checking testbench for the polyphonic voice allocator with a cycle-free voice predictor.
`timescale 1ns / 100ps

module tb_poly_voice_allocator;
  import pva_pkg::*;

  localparam int VOICES        = VOICES_DEF;
  localparam int AGE_BITS      = AGE_BITS_DEF;
  localparam int RANDOM_EVENTS = 1830;
  localparam int QUIET_TAIL    = 250;
  localparam int CYCLE_LIMIT   = 800000;

  // Clock and block inputs, all known from time zero.
  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      out_stall = 1'b0;
  in_word_t  in_data   = '0;
  logic      in_stall;
  logic      out_valid;
  out_word_t out_data;

  // One row of the directed table; the result is typed in only when fixed is set.
  typedef struct {
    in_word_t  word;
    bit        fixed;
    out_word_t result;
  } note_row_t;

  note_row_t note_rows[$];
  out_word_t voice_results_due[$];

  // Predicted voice state.
  logic                voice_live[VOICES];
  logic [KEY_W-1:0]    voice_key[VOICES];
  logic [AGE_BITS-1:0] voice_age[VOICES];
  logic [AGE_BITS-1:0] age_count;

  int gap_pct;
  int stall_pct;
  int stall_left;
  int pct_choices[4] = '{0, 10, 30, 60};
  int mismatches;
  int cycle_count;
  int words_sent;
  int n_retrig, n_idle, n_steal, n_release, n_kill, n_freed;

  poly_voice_allocator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Free-running 10 ns clock.
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Builds an input word from its fields.
  function automatic in_word_t note_event(mode_t m, int k, int v, int d);
    in_word_t w;
    w.mode      = m;
    w.key       = k[KEY_W-1:0];
    w.velocity  = v[VEL_W-1:0];
    w.done_slot = d[2:0];
    return w;
  endfunction

  // Builds a result word from its fields.
  function automatic out_word_t voice_result(action_t a, int s, how_t h, int k, int v, int m);
    out_word_t r;
    r.action         = a;
    r.slot           = s[2:0];
    r.how_chosen     = h;
    r.start_key      = k[KEY_W-1:0];
    r.start_velocity = v[VEL_W-1:0];
    r.release_mask   = m[MASK_W-1:0];
    return r;
  endfunction

  function automatic void add_row(in_word_t w, bit fixed = 1'b0, out_word_t res = '0);
    note_row_t row;
    row.word   = w;
    row.fixed  = fixed;
    row.result = res;
    note_rows.push_back(row);
  endfunction

  // Applies one event to the predicted voice state and returns the result it causes.
  function automatic out_word_t predict_voice_event(in_word_t w);
    out_word_t r;
    int        pick;
    how_t      how;
    bit        found;
    r     = '0;
    pick  = 0;
    how   = HOW_RETRIG;
    found = 1'b0;
    if (w.mode == MODE_ON && w.velocity != '0) begin
      // Same note already sounding first, then the lowest idle slot, then the oldest.
      for (int i = 0; i < VOICES; i++) begin
        if (!found && voice_live[i] && voice_key[i] == w.key) begin
          pick  = i;
          how   = HOW_RETRIG;
          found = 1'b1;
        end
      end
      for (int i = 0; i < VOICES; i++) begin
        if (!found && !voice_live[i]) begin
          pick  = i;
          how   = HOW_IDLE;
          found = 1'b1;
        end
      end
      if (!found) begin
        how = HOW_STEAL;
        for (int i = 1; i < VOICES; i++) begin
          if (voice_age[i] < voice_age[pick]) pick = i;
        end
      end
      age_count        = age_count + AGE_BITS'(1);
      voice_live[pick] = 1'b1;
      voice_key[pick]  = w.key;
      voice_age[pick]  = age_count;
      r.action         = ACT_START;
      r.slot           = pick[2:0];
      r.how_chosen     = how;
      r.start_key      = w.key;
      r.start_velocity = w.velocity;
    end else if (w.mode == MODE_ON || w.mode == MODE_OFF) begin
      // Release marks sounding slots only; they stay active until freed.
      r.action = ACT_RELEASE;
      for (int i = 0; i < VOICES && i < MASK_W; i++) begin
        if (voice_live[i] && voice_key[i] == w.key) r.release_mask[i] = 1'b1;
      end
    end else if (w.mode == MODE_ALL_OFF) begin
      for (int i = 0; i < VOICES; i++) voice_live[i] = 1'b0;
      r.action = ACT_KILL;
    end else begin
      if (int'(w.done_slot) < VOICES) voice_live[w.done_slot] = 1'b0;
      r.action = ACT_FREED;
      r.slot   = w.done_slot;
    end
    return r;
  endfunction

  // Random event: mostly notes from a one-octave pool so that retriggers and steals happen.
  function automatic in_word_t random_note_event();
    int pick;
    int k;
    pick = $urandom_range(0, 99);
    k    = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : 60 + $urandom_range(0, 11);
    if (pick < 45) return note_event(MODE_ON, k, $urandom_range(1, 127), $urandom_range(0, 7));
    if (pick < 50) return note_event(MODE_ON, k, 0, $urandom_range(0, 7));
    if (pick < 70) return note_event(MODE_OFF, k, $urandom_range(0, 127), $urandom_range(0, 7));
    if (pick < 72) begin
      return note_event(MODE_ALL_OFF, $urandom_range(0, 127), $urandom_range(0, 127),
                        $urandom_range(0, 7));
    end
    return note_event(MODE_DONE, $urandom_range(0, 127), $urandom_range(0, 127),
                      $urandom_range(0, 7));
  endfunction

  // Offers one word, waits for the handshake and records the result it owes.
  task automatic send_note_event(in_word_t w, bit fixed, out_word_t res);
    out_word_t predicted;
    if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_data  <= w;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    predicted = predict_voice_event(w);
    voice_results_due.push_back(fixed ? res : predicted);
    words_sent++;
    @(negedge clk);
  endtask

  // Holds the sender off until every owed result has arrived.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    wait (voice_results_due.size() == 0);
    @(negedge clk);
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Receiver stall in random bursts.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (rst_n && stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 12);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Result checker: every accepted word is compared with the oldest owed result.
  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (voice_results_due.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual %h", $time, out_data);
        mismatches++;
      end else begin
        want = voice_results_due.pop_front();
        check_field("action", 32'(want.action), 32'(out_data.action));
        check_field("slot", 32'(want.slot), 32'(out_data.slot));
        check_field("how_chosen", 32'(want.how_chosen), 32'(out_data.how_chosen));
        check_field("start_key", 32'(want.start_key), 32'(out_data.start_key));
        check_field("start_velocity", 32'(want.start_velocity),
                    32'(out_data.start_velocity));
        check_field("release_mask", 32'(want.release_mask), 32'(out_data.release_mask));
        case (want.action)
          ACT_START: begin
            if (want.how_chosen == HOW_RETRIG) n_retrig++;
            else if (want.how_chosen == HOW_IDLE) n_idle++;
            else n_steal++;
          end
          ACT_RELEASE: n_release++;
          ACT_KILL:    n_kill++;
          default:     n_freed++;
        endcase
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: run stopped after %0d cycles with %0d results owed", $time, cycle_count,
               voice_results_due.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Stimulus sequence.
  initial begin
    int n;
    for (int i = 0; i < VOICES; i++) begin
      voice_live[i] = 1'b0;
      voice_key[i]  = '0;
      voice_age[i]  = '0;
    end
    age_count = '0;
    gap_pct   = 0;
    stall_pct = 0;

    // Directed table: extremes, each event kind, release and reuse corner cases.
    add_row(note_event(MODE_ON, 0, 1, 0), 1'b1, voice_result(ACT_START, 0, HOW_IDLE, 0, 1, 0));
    add_row(note_event(MODE_ON, 127, 127, 7), 1'b1,
            voice_result(ACT_START, 1, HOW_IDLE, 127, 127, 0));
    add_row(note_event(MODE_ON, 0, 64, 0), 1'b1,
            voice_result(ACT_START, 0, HOW_RETRIG, 0, 64, 0));
    add_row(note_event(MODE_OFF, 0, 127, 7), 1'b1,
            voice_result(ACT_RELEASE, 0, HOW_RETRIG, 0, 0, 8'h01));
    // Velocity zero acts as a note-off, and the released voice still sounds.
    add_row(note_event(MODE_ON, 0, 0, 0), 1'b1,
            voice_result(ACT_RELEASE, 0, HOW_RETRIG, 0, 0, 8'h01));
    add_row(note_event(MODE_ON, 0, 5, 0));
    for (int k = 10; k < 16; k++) add_row(note_event(MODE_ON, k, 20 * (k - 9), 0));
    // All slots busy: the next two note-ons steal the oldest voices.
    add_row(note_event(MODE_ON, 20, 99, 0));
    add_row(note_event(MODE_ON, 21, 42, 0));
    add_row(note_event(MODE_DONE, 127, 127, 7), 1'b1,
            voice_result(ACT_FREED, 7, HOW_RETRIG, 0, 0, 0));
    // Freeing an idle slot only reports it.
    add_row(note_event(MODE_DONE, 0, 0, 7), 1'b1,
            voice_result(ACT_FREED, 7, HOW_RETRIG, 0, 0, 0));
    // The idle slot still holds its old note, but only live slots retrigger.
    add_row(note_event(MODE_ON, 15, 3, 0));
    add_row(note_event(MODE_OFF, 99, 0, 0), 1'b1,
            voice_result(ACT_RELEASE, 0, HOW_RETRIG, 0, 0, 0));
    add_row(note_event(MODE_ALL_OFF, 127, 127, 7), 1'b1,
            voice_result(ACT_KILL, 0, HOW_RETRIG, 0, 0, 0));
    add_row(note_event(MODE_OFF, 127, 0, 0), 1'b1,
            voice_result(ACT_RELEASE, 0, HOW_RETRIG, 0, 0, 0));
    add_row(note_event(MODE_ON, 127, 127, 5));
    add_row(note_event(MODE_DONE, 85, 42, 0), 1'b1,
            voice_result(ACT_FREED, 0, HOW_RETRIG, 0, 0, 0));
    add_row(note_event(MODE_DONE, 42, 85, 5), 1'b1,
            voice_result(ACT_FREED, 5, HOW_RETRIG, 0, 0, 0));

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    gap_pct   = 20;
    stall_pct = 20;
    foreach (note_rows[i]) send_note_event(note_rows[i].word, note_rows[i].fixed,
                                           note_rows[i].result);
    wait_for_results();

    // Random part with changing idle rates and a quiet tail.
    for (n = 0; n < RANDOM_EVENTS; n++) begin
      if (n >= RANDOM_EVENTS - QUIET_TAIL) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else if (n % 150 == 0) begin
        gap_pct   = pct_choices[$urandom_range(0, 3)];
        stall_pct = pct_choices[$urandom_range(0, 3)];
      end
      if (n % 400 == 399) wait_for_results();
      send_note_event(random_note_event(), 1'b0, '0);
    end
    in_valid <= 1'b0;

    wait (voice_results_due.size() == 0);
    repeat (30) @(posedge clk);

    $display("Sent %0d note events (%0d from the directed table); voices started: %0d retrigger,",
             words_sent, note_rows.size(), n_retrig);
    $display("%0d idle, %0d stolen; %0d releases, %0d all-off kills, %0d slots freed.",
             n_idle, n_steal, n_release, n_kill, n_freed);
    if (mismatches == 0 && voice_results_due.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
